[hdl/gasc_pkg.sv]
// Shared types, constants and codes for the glyph atlas slot cache.
`timescale 1ns / 1ps
package gasc_pkg;

	localparam int CP_W       = 21;
	localparam int SLOT_W     = 9;
	localparam int USED_W     = 10;
	localparam int COORD_W    = 11;
	localparam int STAT_W     = 2;
	localparam int KEY_DEPTH  = 512;
	localparam int NUM_CELLS  = 16;
	localparam int BANK_DEPTH = KEY_DEPTH / NUM_CELLS;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int CELL_IW    = $clog2(NUM_CELLS);

	localparam int DEF_ATLAS_PIXELS = 1024;
	localparam int DEF_CELL_WIDTH   = 32;
	localparam int DEF_CELL_HEIGHT  = 64;

	// '?'
	localparam logic [CP_W-1:0] FALLBACK_RESET = CP_W'(63);

	// scan position at which the last cell of the chain holds the final answer
	localparam int SCAN_LAST = BANK_DEPTH + NUM_CELLS + 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_HIT      = 2'd0,
		STAT_NEW      = 2'd1,
		STAT_FALLBACK = 2'd2,
		STAT_ABSENT   = 2'd3
	} status_t;

	typedef struct packed {
		logic [CP_W-1:0]   key;
		logic [SLOT_W-1:0] col;
		logic [SLOT_W-1:0] row;
	} entry_t;

	typedef struct packed {
		logic               start;
		logic               en;
		logic [BANK_AW-1:0] addr;
		logic [CP_W-1:0]    key;
		logic [USED_W-1:0]  used;
	} scan_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		entry_t            data;
	} wr_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] col;
		logic [SLOT_W-1:0] row;
	} link_t;

endpackage

[hdl/glyph_atlas_slot_cache_top.sv]
// Glyph atlas slot cache: top level with sequencer, allocator and result register.
`timescale 1ns / 1ps
// Each code point is looked up in a chain of 16 cells, each holding 32 atlas
// keys. A lookup pass scans all banks in parallel, one entry per cycle, then
// hands the hit along the chain to the result register; a miss allocates a
// fresh slot while the atlas has room, and a miss on a full atlas runs a
// second pass for the fallback code point. One code point is in flight at
// a time; the next one is accepted while a finished result still waits on
// the output. The allocation store needs no clearing after reset: only
// entries below the fill count are matched.
module glyph_atlas_slot_cache_top
	import gasc_pkg::*;
#(
	parameter int ATLAS_PIXELS = DEF_ATLAS_PIXELS,
	parameter int CELL_WIDTH   = DEF_CELL_WIDTH,
	parameter int CELL_HEIGHT  = DEF_CELL_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CP_W-1:0]    cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CP_W-1:0]    code_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [COORD_W-1:0] u_left,
	output logic [COORD_W-1:0] v_bottom,
	output logic [COORD_W-1:0] u_right,
	output logic [COORD_W-1:0] v_top,
	output logic [STAT_W-1:0]  lookup_status
);

	localparam int COLS    = ATLAS_PIXELS / CELL_WIDTH;
	localparam int ROWS    = ATLAS_PIXELS / CELL_HEIGHT;
	localparam int CAP_RAW = COLS * ROWS;
	localparam int CAP     = (CAP_RAW > KEY_DEPTH) ? KEY_DEPTH : CAP_RAW;
	localparam int CNT_W   = $clog2(SCAN_LAST + 1);

	localparam logic [USED_W-1:0]  CAP_V      = USED_W'(CAP);
	localparam logic [SLOT_W-1:0]  COL_LAST   = SLOT_W'((COLS > 0) ? COLS - 1 : 0);
	localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(SCAN_LAST);
	localparam logic [CNT_W-1:0]   CNT_BANK   = CNT_W'(BANK_DEPTH);
	localparam logic [COORD_W-1:0] CW_V       = COORD_W'(CELL_WIDTH);
	localparam logic [COORD_W-1:0] CH_V       = COORD_W'(CELL_HEIGHT);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               fb_q, fb_d;
	logic [CP_W-1:0]    key_q;
	logic [CP_W-1:0]    fallback_q;
	logic [USED_W-1:0]  used_q;
	logic [SLOT_W-1:0]  col_q;
	logic [SLOT_W-1:0]  row_q;
	logic               alloc;
	logic               in_acc;
	logic               load_out;

	logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
	logic [SLOT_W-1:0]  res_col_q, res_col_d;
	logic [SLOT_W-1:0]  res_row_q, res_row_d;
	status_t            res_stat_q, res_stat_d;

	logic               out_valid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [COORD_W-1:0] out_ul_q, out_vb_q, out_ur_q, out_vt_q;
	status_t            out_stat_q;
	logic [COORD_W-1:0] px, py;

	scan_t              scan;
	wr_t                wr;
	link_t              link [NUM_CELLS+1];

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	assign scan.start = (state_q == ST_SCAN) && (cnt_q == '0);
	assign scan.en    = (state_q == ST_SCAN) && (cnt_q < CNT_BANK);
	assign scan.addr  = cnt_q[BANK_AW-1:0];
	assign scan.key   = fb_q ? fallback_q : key_q;
	assign scan.used  = used_q;

	assign wr.en        = alloc;
	assign wr.slot      = used_q[SLOT_W-1:0];
	assign wr.data.key  = key_q;
	assign wr.data.col  = col_q;
	assign wr.data.row  = row_q;

	assign link[0] = '0;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		gasc_cell #(
			.CELL_IDX(c)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.scan    (scan),
			.wr      (wr),
			.link_in (link[c]),
			.link_out(link[c+1])
		);
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		fb_d       = fb_q;
		alloc      = 1'b0;
		res_slot_d = res_slot_q;
		res_col_d  = res_col_q;
		res_row_d  = res_row_q;
		res_stat_d = res_stat_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_SCAN;
					cnt_d   = '0;
					fb_d    = 1'b0;
				end
			end
			ST_SCAN: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					if (link[NUM_CELLS].found) begin
						res_slot_d = link[NUM_CELLS].slot;
						res_col_d  = link[NUM_CELLS].col;
						res_row_d  = link[NUM_CELLS].row;
						res_stat_d = fb_q ? STAT_FALLBACK : STAT_HIT;
						state_d    = ST_EMIT;
					end else if (!fb_q && (used_q < CAP_V)) begin
						alloc      = 1'b1;
						res_slot_d = used_q[SLOT_W-1:0];
						res_col_d  = col_q;
						res_row_d  = row_q;
						res_stat_d = STAT_NEW;
						state_d    = ST_EMIT;
					end else if (!fb_q) begin
						// atlas full: run a second pass for the fallback code point
						fb_d  = 1'b1;
						cnt_d = '0;
					end else begin
						res_slot_d = '0;
						res_col_d  = '0;
						res_row_d  = '0;
						res_stat_d = STAT_ABSENT;
						state_d    = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			fb_q       <= 1'b0;
			used_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
			fallback_q <= FALLBACK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			fb_q    <= fb_d;
			if (cfg_we) begin
				fallback_q <= cfg_wdata;
			end
			if (alloc) begin
				used_q <= used_q + USED_W'(1);
				// advance the row-major grid position alongside the fill count
				if (col_q == COL_LAST) begin
					col_q <= '0;
					row_q <= row_q + SLOT_W'(1);
				end else begin
					col_q <= col_q + SLOT_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= code_point;
		end
		res_slot_q <= res_slot_d;
		res_col_q  <= res_col_d;
		res_row_q  <= res_row_d;
		res_stat_q <= res_stat_d;
	end

	assign px = COORD_W'(res_col_q) * CW_V;
	assign py = COORD_W'(res_row_q) * CH_V;

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_stat_q <= res_stat_q;
			if (res_stat_q == STAT_ABSENT) begin
				out_slot_q <= '0;
				out_ul_q   <= '0;
				out_vb_q   <= '0;
				out_ur_q   <= '0;
				out_vt_q   <= '0;
			end else begin
				out_slot_q <= res_slot_q;
				out_ul_q   <= px;
				out_vb_q   <= py + CH_V;
				out_ur_q   <= px + CW_V;
				out_vt_q   <= py;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign slot_index    = out_slot_q;
	assign u_left        = out_ul_q;
	assign v_bottom      = out_vb_q;
	assign u_right       = out_ur_q;
	assign v_top         = out_vt_q;
	assign lookup_status = out_stat_q;

endmodule

[hdl/gasc_cell.sv]
// One cell of the search chain: a bank of stored keys, a scan comparator and a chain link.
`timescale 1ns / 1ps
module gasc_cell
	import gasc_pkg::*;
#(
	parameter int CELL_IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  scan_t scan,
	input  wr_t   wr,
	input  link_t link_in,
	output link_t link_out
);

	localparam logic [CELL_IW-1:0] ME = CELL_IW'(CELL_IDX);

	entry_t             mem [BANK_DEPTH];
	entry_t             rd_s1;
	logic [BANK_AW-1:0] addr_s1;
	logic               chk_s1;
	logic               hit_q;
	logic [SLOT_W-1:0]  own_slot_q;
	logic [SLOT_W-1:0]  own_col_q;
	logic [SLOT_W-1:0]  own_row_q;
	logic [SLOT_W-1:0]  slot_s1;
	logic               match;

	always_ff @(posedge clk) begin
		if (wr.en && (wr.slot[SLOT_W-1:BANK_AW] == ME)) begin
			mem[wr.slot[BANK_AW-1:0]] <= wr.data;
		end
		rd_s1   <= mem[scan.addr];
		addr_s1 <= scan.addr;
	end

	assign slot_s1 = {ME, addr_s1};
	// only allocated entries take part; the rest of the bank may hold anything
	assign match = chk_s1 && ({1'b0, slot_s1} < scan.used) && (rd_s1.key == scan.key);

	always_ff @(posedge clk) begin
		if (match) begin
			own_slot_q <= slot_s1;
			own_col_q  <= rd_s1.col;
			own_row_q  <= rd_s1.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1   <= 1'b0;
			hit_q    <= 1'b0;
			link_out <= '0;
		end else begin
			chk_s1 <= scan.en;
			if (scan.start) begin
				hit_q <= 1'b0;
			end else if (match) begin
				hit_q <= 1'b1;
			end
			// pass own hit downstream, else forward what arrives from upstream
			if (hit_q) begin
				link_out <= '{found: 1'b1, slot: own_slot_q, col: own_col_q, row: own_row_q};
			end else begin
				link_out <= link_in;
			end
		end
	end

endmodule

[hdl/gasc_checker.sv]
// Port-level checks for the glyph atlas slot cache, bound to the top level.
`timescale 1ns / 1ps
module gasc_checker
	import gasc_pkg::*;
#(
	parameter int CELL_WIDTH  = DEF_CELL_WIDTH,
	parameter int CELL_HEIGHT = DEF_CELL_HEIGHT
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [SLOT_W-1:0]  slot_index,
	input logic [COORD_W-1:0] u_left,
	input logic [COORD_W-1:0] v_bottom,
	input logic [COORD_W-1:0] u_right,
	input logic [COORD_W-1:0] v_top,
	input logic [STAT_W-1:0]  lookup_status
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(lookup_status))
		else $error("result changed while stalled");

	// one transaction in flight: no new input right after one is taken
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a lookup is in flight");

	// an absent fallback carries an all-zero cell
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (lookup_status == STAT_ABSENT) |->
		(slot_index == '0) && (u_left == '0) && (u_right == '0) &&
		(v_top == '0) && (v_bottom == '0))
		else $error("absent fallback with non-zero cell");

	// corners of a real cell lie one cell size apart
	a_cell_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (lookup_status != STAT_ABSENT) |->
		(COORD_W'(u_right - u_left) == COORD_W'(CELL_WIDTH)) &&
		(COORD_W'(v_bottom - v_top) == COORD_W'(CELL_HEIGHT)))
		else $error("texture corners do not span one cell");

endmodule

bind glyph_atlas_slot_cache_top gasc_checker #(
	.CELL_WIDTH (CELL_WIDTH),
	.CELL_HEIGHT(CELL_HEIGHT)
) u_gasc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.slot_index   (slot_index),
	.u_left       (u_left),
	.v_bottom     (v_bottom),
	.u_right      (u_right),
	.v_top        (v_top),
	.lookup_status(lookup_status)
);
